### rtl/pid_integral_separation_antiwindup_core_defines.svh
// ---------------------------------------------------------------------------
// PID core assertion macros
// Shared concurrent assertion wrappers for the PID core RTL.
// ---------------------------------------------------------------------------
`ifndef PID_INTEGRAL_SEPARATION_ANTIWINDUP_CORE_DEFINES_SVH
`define PID_INTEGRAL_SEPARATION_ANTIWINDUP_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PIDISA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PIDISA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pidisa_pkg.sv
// ---------------------------------------------------------------------------
// PID core package
// Types, register indexes and fixed constants shared by the PID core.
// ---------------------------------------------------------------------------
package pidisa_pkg;

    localparam int VAL_W  = 24;  // Q16.8 values
    localparam int ERR_W  = 25;  // error, one bit of growth
    localparam int SUM_W  = 32;  // integral, Q24.8
    localparam int GAIN_W = 16;  // Q4.12 gains
    localparam int THR_W  = 23;
    localparam int IDX_W  = 3;

    typedef enum logic [IDX_W-1:0] {
        CFG_PROP_GAIN  = 3'd0,
        CFG_INTEG_GAIN = 3'd1,
        CFG_DERIV_GAIN = 3'd2,
        CFG_UPPER_LIM  = 3'd3,
        CFG_LOWER_LIM  = 3'd4,
        CFG_SEP_THRESH = 3'd5
    } cfg_sel_t;

    typedef struct packed {
        logic        [GAIN_W-1:0] prop_gain;
        logic        [GAIN_W-1:0] integ_gain;
        logic        [GAIN_W-1:0] deriv_gain;
        logic signed [VAL_W-1:0]  upper_limit;
        logic signed [VAL_W-1:0]  lower_limit;
        logic        [THR_W-1:0]  separation_threshold;
    } cfg_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] last_output;
        logic signed [ERR_W-1:0] last_error;
        logic signed [SUM_W-1:0] error_sum;
    } state_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] control_out;
        logic                    integral_used;
        logic                    saturated;
    } result_t;

    localparam cfg_t CFG_RESET = '{
        prop_gain:            16'd819,
        integ_gain:           16'd410,
        deriv_gain:           16'd819,
        upper_limit:          24'sd65280,
        lower_limit:          -24'sd65280,
        separation_threshold: 23'd25600
    };

endpackage

### rtl/pidisa_calc.sv
// ---------------------------------------------------------------------------
// PID core step datapath
// One control update: error, separation and anti-windup decision, integral
// update with clamp, three gain products, rounding and output clamp.
// ---------------------------------------------------------------------------
module pidisa_calc (
    input  logic signed [pidisa_pkg::VAL_W-1:0] setpoint,
    input  pidisa_pkg::cfg_t                    cfg,
    input  pidisa_pkg::state_t                  st,
    output pidisa_pkg::result_t                 res,
    output pidisa_pkg::state_t                  st_next
);
    import pidisa_pkg::*;

    localparam int ACC_W = 50;
    localparam int Y_W   = ACC_W - 12;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2048);
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] OUT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] OUT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    logic signed [ERR_W-1:0]    err;
    logic        [ERR_W-1:0]    mag;
    logic                       use_int;
    logic                       add;
    logic signed [SUM_W:0]      sum_wide;
    logic                       sum_ovf;
    logic signed [SUM_W-1:0]    sum_clamped;
    logic signed [SUM_W-1:0]    sum_new;
    logic signed [ERR_W:0]      diff;
    logic signed [GAIN_W:0]     kp_s, ki_s, kd_s;
    logic signed [ACC_W-1:0]    prod_p, prod_d, prod_i, acc;
    logic signed [Y_W-1:0]      y_wide;
    logic        [Y_W-VAL_W:0]  y_hi;
    logic                       out_ovf;

    assign err = ERR_W'(setpoint) - ERR_W'(st.last_output);
    assign mag = err[ERR_W-1] ? unsigned'(-err) : unsigned'(err);
    assign use_int = mag <= {{(ERR_W-THR_W){1'b0}}, cfg.separation_threshold};

    // anti-windup: upper test first, so crossed limits follow the upper rule
    always_comb begin
        if (st.last_output > cfg.upper_limit) begin
            add = err[ERR_W-1];
        end else if (st.last_output < cfg.lower_limit) begin
            add = !err[ERR_W-1] && (err != '0);
        end else begin
            add = 1'b1;
        end
    end

    assign sum_wide    = (SUM_W+1)'(st.error_sum) + (SUM_W+1)'(err);
    assign sum_ovf     = sum_wide[SUM_W] != sum_wide[SUM_W-1];
    assign sum_clamped = sum_ovf ? (sum_wide[SUM_W] ? SUM_MIN : SUM_MAX)
                                 : sum_wide[SUM_W-1:0];
    assign sum_new     = (use_int && add) ? sum_clamped : st.error_sum;

    assign diff = (ERR_W+1)'(err) - (ERR_W+1)'(st.last_error);

    assign kp_s = signed'({1'b0, cfg.prop_gain});
    assign ki_s = use_int ? signed'({1'b0, cfg.integ_gain}) : '0;
    assign kd_s = signed'({1'b0, cfg.deriv_gain});

    assign prod_p = ACC_W'(kp_s) * ACC_W'(err);
    assign prod_d = ACC_W'(kd_s) * ACC_W'(diff);
    assign prod_i = ACC_W'(ki_s) * ACC_W'(sum_new);
    assign acc    = prod_p + prod_d + prod_i + ROUND_HALF;

    // floor shift by 12 is a plain slice of the two's complement sum
    assign y_wide  = signed'(acc[ACC_W-1:12]);
    assign y_hi    = y_wide[Y_W-1:VAL_W-1];
    assign out_ovf = !((&y_hi) || !(|y_hi));

    always_comb begin
        res.control_out   = out_ovf ? (y_wide[Y_W-1] ? OUT_MIN : OUT_MAX)
                                    : y_wide[VAL_W-1:0];
        res.integral_used = use_int;
        res.saturated     = out_ovf || (use_int && add && sum_ovf);
        st_next.last_output = res.control_out;
        st_next.last_error  = err;
        st_next.error_sum   = sum_new;
    end

endmodule

### rtl/pid_integral_separation_antiwindup_core.sv
// ---------------------------------------------------------------------------
// Positional PID core with integral separation and anti-windup
// Q16.8 speed controller; previous output stands in for the measurement.
// ---------------------------------------------------------------------------
// Usage: each setpoint word yields exactly one result word. The core takes
// one word per clock while the result side is not stalled; a word passes
// the input register, then the result register. Throughput is one word
// per cycle, set by the update loop: the error, integral and the three gain
// products (17x25, 17x26, 17x32) all feed back into last output / error /
// integral state before the next word can be computed. An input register and
// a result register decouple the two sides, so a new setpoint is taken while
// a finished result waits. Gains and limits are written over the cfg port
// (index 0..5, always ready); write them only while the core is idle.
// ---------------------------------------------------------------------------
`include "pid_integral_separation_antiwindup_core_defines.svh"

module pid_integral_separation_antiwindup_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // setpoint channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [pidisa_pkg::VAL_W-1:0] s_setpoint,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [pidisa_pkg::VAL_W-1:0] m_control_out,
    output logic                                m_integral_used,
    output logic                                m_saturated,
    // register write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pidisa_pkg::IDX_W-1:0]        cfg_index,
    input  logic [pidisa_pkg::VAL_W-1:0]        cfg_data
);
    import pidisa_pkg::*;

    cfg_t                    cfg_reg;
    state_t                  state_reg;
    state_t                  state_next;
    result_t                 res_next;
    result_t                 res_reg;
    logic signed [VAL_W-1:0] setpoint_reg;
    logic                    in_vld_reg;
    logic                    m_valid_reg;
    logic                    advance;

    // ---------------- register file ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_PROP_GAIN:  cfg_reg.prop_gain   <= cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN: cfg_reg.integ_gain  <= cfg_data[GAIN_W-1:0];
                CFG_DERIV_GAIN: cfg_reg.deriv_gain  <= cfg_data[GAIN_W-1:0];
                CFG_UPPER_LIM:  cfg_reg.upper_limit <= signed'(cfg_data);
                CFG_LOWER_LIM:  cfg_reg.lower_limit <= signed'(cfg_data);
                CFG_SEP_THRESH: cfg_reg.separation_threshold <= cfg_data[THR_W-1:0];
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    // ---------------- handshake ----------------
    // Input stage moves to the result register when that register is empty
    // or being drained this cycle; controller state updates on the same edge.
    assign advance = in_vld_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            state_reg   <= '0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            setpoint_reg <= s_setpoint;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    // ---------------- control update ----------------
    pidisa_calc u_calc (
        .setpoint (setpoint_reg),
        .cfg      (cfg_reg),
        .st       (state_reg),
        .res      (res_next),
        .st_next  (state_next)
    );

    assign m_valid         = m_valid_reg;
    assign m_control_out   = res_reg.control_out;
    assign m_integral_used = res_reg.integral_used;
    assign m_saturated     = res_reg.saturated;

    // ---------------- checks ----------------
    // separated step must leave the integral untouched
    `PIDISA_ASSERT_NEXT(a_sep_holds_sum, aclk, aresetn, advance && !res_next.integral_used, $stable(state_reg.error_sum), "integral changed on a separated step")
    // a word leaving the input stage always lands in the result register
    `PIDISA_ASSERT_NEXT(a_adv_loads_out, aclk, aresetn, advance, m_valid_reg, "result register not loaded")
    // fed-back output matches the result on display
    `PIDISA_ASSERT_NOW(a_fb_matches_out, aclk, aresetn, m_valid_reg, state_reg.last_output == res_reg.control_out, "feedback state out of step with result")
    // an accepted setpoint is held in the input stage
    `PIDISA_ASSERT_NEXT(a_accept_fills_in, aclk, aresetn, s_valid && s_ready, in_vld_reg, "accepted setpoint lost")

endmodule

### sim/tb_pid_integral_separation_antiwindup_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// PID core testbench
// Streams setpoint words into the PID core and checks every result word
// against a cycle-free model of the controller kept in the bench. Gains,
// limits and the separation threshold are rewritten between phases. Both
// channels stall at random.
// ---------------------------------------------------------------------------
module tb_pid_integral_separation_antiwindup_core;
    import pidisa_pkg::*;

    localparam int    IDLE_PCT    = 36;     // percent of cycles a side idles
    localparam int    STALL_LIMIT = 4000;   // cycles with no handshake at all
    localparam int    TAIL_CYCLES = 16;
    localparam int    PHASE_ITEMS = 130;
    localparam int    N_PHASES    = 7;

    localparam longint OUT_MAX = 64'sd8388607;
    localparam longint OUT_MIN = -64'sd8388608;
    localparam longint SUM_MAX = 64'sd2147483647;
    localparam longint SUM_MIN = -64'sd2147483648;
    localparam longint THR_MAX = 64'sd8388607;

    // register indexes the core does not decode
    localparam logic [IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // clock, reset and DUT ports
    logic                    aclk            = 1'b0;
    logic                    aresetn         = 1'b0;
    logic                    s_valid         = 1'b0;
    logic                    s_ready;
    logic signed [VAL_W-1:0] s_setpoint      = '0;
    logic                    m_valid;
    logic                    m_ready         = 1'b0;
    logic signed [VAL_W-1:0] m_control_out;
    logic                    m_integral_used;
    logic                    m_saturated;
    logic                    cfg_valid       = 1'b0;
    logic                    cfg_ready;
    logic [IDX_W-1:0]        cfg_index       = '0;
    logic [VAL_W-1:0]        cfg_data        = '0;

    // setpoints waiting to be sent, and results owed by the core
    logic signed [VAL_W-1:0] setpoint_q[$];
    result_t                 pending_ctrl[$];

    // bench copy of the core: registers, live state, and a look-ahead copy
    // used only to aim setpoints at a wanted error
    cfg_t                    cfg_model = CFG_RESET;
    state_t                  pid_st    = '0;
    state_t                  plan_st   = '0;

    logic                    hold_sender = 1'b0;
    logic                    steady      = 1'b0;   // no idling on either side

    logic signed [VAL_W-1:0] drv_sp;
    result_t                 drv_res;
    result_t                 plan_res;
    result_t                 mon_want;

    int n_errors  = 0;
    int n_sent    = 0;
    int n_checked = 0;
    int n_integ   = 0;
    int n_clamp   = 0;
    int n_writes  = 0;
    int stall_cycles = 0;

    pid_integral_separation_antiwindup_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_setpoint      (s_setpoint),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_control_out   (m_control_out),
        .m_integral_used (m_integral_used),
        .m_saturated     (m_saturated),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Controller model. One call is one PID step: error against the last
    // output, integral separation, anti-windup gate, clamped integral, then
    // the Q.20 sum rounded half up to Q.8 and clamped to 24 bits.
    // -----------------------------------------------------------------------
    task automatic pid_update(input cfg_t c, inout state_t st,
                              input logic signed [VAL_W-1:0] sp, output result_t r);
        longint err, mag, nsum, acc, y, last_o;
        bit     use_i, add, sat;
        begin
            last_o = $signed(st.last_output);
            err    = longint'(sp) - last_o;
            mag    = (err < 0) ? -err : err;
            use_i  = (mag <= longint'(c.separation_threshold));
            sat    = 1'b0;
            add    = 1'b0;
            if (use_i) begin
                // upper bound is tested first, even when the bounds are crossed
                if (last_o > longint'($signed(c.upper_limit)))
                    add = (err < 0);
                else if (last_o < longint'($signed(c.lower_limit)))
                    add = (err > 0);
                else
                    add = 1'b1;
                if (add) begin
                    nsum = longint'($signed(st.error_sum)) + err;
                    if (nsum > SUM_MAX) begin
                        nsum = SUM_MAX;
                        sat  = 1'b1;
                    end
                    if (nsum < SUM_MIN) begin
                        nsum = SUM_MIN;
                        sat  = 1'b1;
                    end
                    st.error_sum = nsum[SUM_W-1:0];
                end
            end
            acc = longint'(c.prop_gain) * err
                + longint'(c.deriv_gain) * (err - longint'($signed(st.last_error)));
            if (use_i)
                acc = acc + longint'(c.integ_gain) * longint'($signed(st.error_sum));
            y = (acc + 64'sd2048) >>> 12;
            if (y > OUT_MAX) begin
                y   = OUT_MAX;
                sat = 1'b1;
            end
            if (y < OUT_MIN) begin
                y   = OUT_MIN;
                sat = 1'b1;
            end
            st.last_error    = err[ERR_W-1:0];
            st.last_output   = y[VAL_W-1:0];
            r.control_out    = y[VAL_W-1:0];
            r.integral_used  = use_i;
            r.saturated      = sat;
        end
    endtask

    // register write as the core decodes it; spare indexes change nothing
    task automatic apply_reg(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        begin
            case (idx)
                CFG_PROP_GAIN:  cfg_model.prop_gain            = data[GAIN_W-1:0];
                CFG_INTEG_GAIN: cfg_model.integ_gain           = data[GAIN_W-1:0];
                CFG_DERIV_GAIN: cfg_model.deriv_gain           = data[GAIN_W-1:0];
                CFG_UPPER_LIM:  cfg_model.upper_limit          = data;
                CFG_LOWER_LIM:  cfg_model.lower_limit          = data;
                CFG_SEP_THRESH: cfg_model.separation_threshold = data[THR_W-1:0];
                default: ;
            endcase
        end
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        begin
            @(posedge aclk);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            @(posedge aclk);
            while (!cfg_ready)
                @(posedge aclk);
            cfg_valid <= 1'b0;
            apply_reg(idx, data);
            n_writes++;
        end
    endtask

    // all six registers plus one write to an undecoded index; unused upper
    // data bits carry junk so the core must ignore them
    task automatic write_all(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                             input logic [GAIN_W-1:0] kd, input longint up,
                             input longint lo, input longint thr);
        logic [VAL_W-1:0] junk;
        logic [VAL_W-1:0] tmp;
        begin
            junk = VAL_W'($urandom);
            write_reg(CFG_PROP_GAIN, {junk[23:16], kp});
            junk = VAL_W'($urandom);
            write_reg(CFG_INTEG_GAIN, {junk[23:16], ki});
            junk = VAL_W'($urandom);
            write_reg(($urandom_range(1) != 0) ? CFG_SPARE_LO : CFG_SPARE_HI, junk);
            junk = VAL_W'($urandom);
            write_reg(CFG_DERIV_GAIN, {junk[23:16], kd});
            tmp = up[VAL_W-1:0];
            write_reg(CFG_UPPER_LIM, tmp);
            tmp = lo[VAL_W-1:0];
            write_reg(CFG_LOWER_LIM, tmp);
            junk = VAL_W'($urandom);
            tmp  = {junk[23], thr[THR_W-1:0]};
            write_reg(CFG_SEP_THRESH, tmp);
        end
    endtask

    // queue a setpoint and advance the look-ahead copy
    task automatic push_sp(input logic signed [VAL_W-1:0] sp);
        begin
            pid_update(cfg_model, plan_st, sp, plan_res);
            setpoint_q.push_back(sp);
        end
    endtask

    // queue the setpoint that gives error e against the predicted last output
    task automatic push_err(input longint e);
        longint t;
        begin
            t = longint'($signed(plan_st.last_output)) + e;
            if (t > OUT_MAX) t = OUT_MAX;
            if (t < OUT_MIN) t = OUT_MIN;
            push_sp(t[VAL_W-1:0]);
        end
    endtask

    // random setpoints aimed at the interesting error bands
    task automatic fill_random(input int n);
        longint thr, e;
        int     k;
        logic [31:0] raw;
        begin
            for (int i = 0; i < n; i++) begin
                thr = longint'(cfg_model.separation_threshold);
                k   = $urandom_range(99);
                raw = $urandom;
                if (k < 30) begin
                    e = longint'($urandom_range(thr[31:0]));
                    push_err(raw[0] ? -e : e);
                end else if (k < 45) begin
                    // right at the separation edge
                    e = thr + longint'($urandom_range(4)) - 64'sd2;
                    push_err(raw[0] ? -e : e);
                end else if (k < 60) begin
                    e = longint'($urandom_range(255));
                    push_err(raw[0] ? -e : e);
                end else if (k < 75) begin
                    push_sp(raw[VAL_W-1:0]);
                end else if (k < 85) begin
                    case (raw[1:0])
                        2'd0: push_sp(OUT_MAX[VAL_W-1:0]);
                        2'd1: push_sp(OUT_MIN[VAL_W-1:0]);
                        2'd2: push_sp('0);
                        default: push_sp('1);
                    endcase
                end else begin
                    push_err(longint'($urandom_range(16777215)) - 64'sd8388608);
                end
            end
        end
    endtask

    // let about half the queue go, hold the sender until every owed result
    // is back, then release and drain completely
    task automatic settle(input int total);
        begin
            while (setpoint_q.size() > total / 2)
                @(posedge aclk);
            hold_sender <= 1'b1;
            while (pending_ctrl.size() != 0 || s_valid)
                @(posedge aclk);
            hold_sender <= 1'b0;
            while (setpoint_q.size() != 0 || s_valid || pending_ctrl.size() != 0)
                @(posedge aclk);
        end
    endtask

    task automatic flag_mismatch(input string what);
        begin
            n_errors++;
            $display("%0t ns: mismatch: %s", $time, what);
        end
    endtask

    // -----------------------------------------------------------------------
    // Setpoint driver. The expected word is computed when a setpoint is put
    // on the bus; valid then holds until the core takes it, so the order of
    // expectations matches the order of acceptance.
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            s_setpoint <= '0;
        end else if (!s_valid || s_ready) begin
            if (setpoint_q.size() != 0 && !hold_sender &&
                (steady || $urandom_range(99) >= IDLE_PCT)) begin
                drv_sp = setpoint_q.pop_front();
                pid_update(cfg_model, pid_st, drv_sp, drv_res);
                pending_ctrl.push_back(drv_res);
                s_valid    <= 1'b1;
                s_setpoint <= drv_sp;
                n_sent++;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Result monitor: compare each accepted word with the oldest expectation.
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_ctrl.size() == 0) begin
                    flag_mismatch($sformatf("result word %0d with nothing expected, out %0d",
                                            n_checked, m_control_out));
                end else begin
                    mon_want = pending_ctrl.pop_front();
                    if (m_control_out !== mon_want.control_out)
                        flag_mismatch($sformatf("word %0d control_out %0d, expected %0d",
                                                n_checked, m_control_out,
                                                mon_want.control_out));
                    if (m_integral_used !== mon_want.integral_used)
                        flag_mismatch($sformatf("word %0d integral_used %b, expected %b",
                                                n_checked, m_integral_used,
                                                mon_want.integral_used));
                    if (m_saturated !== mon_want.saturated)
                        flag_mismatch($sformatf("word %0d saturated %b, expected %b",
                                                n_checked, m_saturated, mon_want.saturated));
                    if (mon_want.integral_used) n_integ++;
                    if (mon_want.saturated) n_clamp++;
                end
                n_checked++;
            end
            m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog: too long without any handshake on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("tb_pid_integral_separation_antiwindup_core: FAIL");
                $finish;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Test sequence
    // -----------------------------------------------------------------------
    initial begin
        longint thr, up, lo, a, b;
        int     guard;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed words under the reset settings: separation edge on both
        // sides, full-scale steps, and small errors while the last output
        // sits above the upper bound and below the lower bound
        plan_st = pid_st;
        thr     = longint'(cfg_model.separation_threshold);
        push_sp('0);
        push_err(64'sd0);
        push_err(thr);
        push_err(thr + 64'sd1);
        push_err(-thr);
        push_err(-thr - 64'sd1);
        push_err(64'sd1);
        push_err(-64'sd1);
        push_sp(OUT_MAX[VAL_W-1:0]);
        push_err(64'sd12800);
        push_err(-64'sd12800);
        push_sp(OUT_MIN[VAL_W-1:0]);
        push_err(64'sd12800);
        push_err(-64'sd12800);
        push_sp(OUT_MAX[VAL_W-1:0]);
        push_sp(OUT_MIN[VAL_W-1:0]);
        push_sp(OUT_MAX[VAL_W-1:0]);
        push_sp('1);
        push_sp(24'sd1);
        push_err(64'sd0);
        settle(setpoint_q.size());

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    // zero gains keep the output at 0, so error == setpoint and
                    // the integral runs into both clamps
                    write_all('0, '0, '0, OUT_MAX, OUT_MIN, THR_MAX);
                end
                1: write_all('1, '1, '1, OUT_MAX, OUT_MIN, THR_MAX);
                2: write_all('0, '0, '0, 64'sd0, 64'sd0, 64'sd0);
                3: begin
                    // crossed bounds: lower above upper
                    lo = longint'($urandom_range(1, 1 << 20));
                    up = -longint'($urandom_range(1, 1 << 20));
                    write_all(GAIN_W'($urandom_range(4095)), GAIN_W'($urandom_range(4095)),
                              GAIN_W'($urandom_range(4095)), up, lo,
                              longint'($urandom_range(1 << 16)));
                end
                4: write_all(CFG_RESET.prop_gain, CFG_RESET.integ_gain,
                             CFG_RESET.deriv_gain,
                             longint'($signed(CFG_RESET.upper_limit)),
                             longint'($signed(CFG_RESET.lower_limit)),
                             longint'(CFG_RESET.separation_threshold));
                default: begin
                    a = longint'($urandom_range(1 << 22)) - 64'sd2097152;
                    b = longint'($urandom_range(1 << 22)) - 64'sd2097152;
                    thr = ($urandom_range(1) != 0) ? longint'($urandom_range(1 << 20))
                                                   : longint'($urandom_range(2000));
                    write_all(GAIN_W'(($urandom_range(1) != 0) ? $urandom_range(65535)
                                                               : $urandom_range(2000)),
                              GAIN_W'(($urandom_range(1) != 0) ? $urandom_range(65535)
                                                               : $urandom_range(2000)),
                              GAIN_W'(($urandom_range(1) != 0) ? $urandom_range(65535)
                                                               : $urandom_range(2000)),
                              (a > b) ? a : b, (a > b) ? b : a, thr);
                end
            endcase
            steady  <= (ph == 3);   // one long stretch with no idling
            plan_st = pid_st;
            if (ph == 0) begin
                guard = 0;
                while ($signed(plan_st.error_sum) != SUM_MAX && guard < 600) begin
                    push_sp(OUT_MAX[VAL_W-1:0]);
                    guard++;
                end
                repeat (3) push_sp(OUT_MAX[VAL_W-1:0]);
                // most negative step that still counts as inside the threshold
                guard = 0;
                while ($signed(plan_st.error_sum) != SUM_MIN && guard < 600) begin
                    push_sp(OUT_MIN[VAL_W-1:0] + 24'd1);
                    guard++;
                end
                repeat (3) push_sp(OUT_MIN[VAL_W-1:0] + 24'd1);
            end else begin
                fill_random(PHASE_ITEMS);
            end
            settle(setpoint_q.size());
        end
        steady <= 1'b0;

        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Sent %0d setpoints under %0d register writes; %0d results checked,",
                 n_sent, n_writes, n_checked);
        $display("%0d with the integral active and %0d with a clamp applied.",
                 n_integ, n_clamp);
        if (n_errors == 0 && pending_ctrl.size() == 0)
            $display("tb_pid_integral_separation_antiwindup_core: PASS");
        else
            $display("tb_pid_integral_separation_antiwindup_core: FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/pidisa_pkg.sv
rtl/pidisa_calc.sv
rtl/pid_integral_separation_antiwindup_core.sv
sim/tb_pid_integral_separation_antiwindup_core.sv
